FILE: src/lsap_pkg.sv
`timescale 1ns / 1ps
package lsap_pkg;
  localparam int Channels = 16;
  localparam int FracBits = 8;
  localparam int ChW = 4;
  localparam int SmpW = 10;
  localparam int LvlW = 12;
  localparam int SvalW = 16;
  localparam int NumW = 24;
  localparam int DenW = 20;
  localparam int PosW = 12;
  localparam int SvalLim = 32767;
  localparam int PosLim = 2047;
  localparam int DarkReset = 1024;
  localparam int ThrReset = 128;

  localparam logic [0:0] RegMode = 1'b0;
  localparam logic [0:0] RegThr = 1'b1;

  typedef enum logic [2:0] {
    BkIdle, BkPrep, BkLoad, BkDiv, BkAcc, BkPosDiv, BkOut
  } bk_state_e;

  typedef struct packed {
    logic last;
    logic [ChW-1:0] channel;
    logic led_on;
    logic [SmpW-1:0] sample;
  } item_t;

  typedef struct packed {
    logic signed [PosW-1:0] position;
    logic [15:0] line_bits;
    logic [4:0] lit_count;
    logic all_dark;
    logic no_line;
    logic uncalibrated;
  } result_t;
endpackage

FILE: src/lsap_front.sv
`timescale 1ns / 1ps
// input queue: two-entry fifo between the input port and the scan engine
module lsap_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  lsap_pkg::item_t     item_i,
  output logic                avail_o,
  input  logic                take_i,
  output lsap_pkg::item_t     item_o
);
  lsap_pkg::item_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign full_o  = cnt_q == 2'd2;
  assign avail_o = cnt_q != 2'd0;
  assign wr = push_i && !full_o;
  assign rd = take_i && avail_o;
  assign item_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count overflow");
  a_avail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr && !rd |=> avail_o) else $error("written entry not visible");
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !rd |=> full_o) else $error("full dropped without read");
`endif
endmodule

FILE: src/lsap_div.sv
`timescale 1ns / 1ps
// restoring divider, unsigned magnitudes, one quotient bit a cycle
module lsap_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [lsap_pkg::NumW+lsap_pkg::FracBits-1:0] dividend_i,
  input  logic [lsap_pkg::DenW-1:0] divisor_i,
  output logic                      done_o,
  output logic [lsap_pkg::NumW+lsap_pkg::FracBits-1:0] quot_o
);
  localparam int W = lsap_pkg::NumW + lsap_pkg::FracBits;
  logic [W-1:0] q_q;
  logic [lsap_pkg::DenW:0] r_q;
  logic [lsap_pkg::DenW-1:0] d_q;
  logic [5:0] n_q;
  logic busy_q;
  logic [lsap_pkg::DenW:0] r_sh, r_sub;

  assign r_sh  = {r_q[lsap_pkg::DenW-1:0], q_q[W-1]};
  assign r_sub = r_sh - {1'b0, d_q};
  assign quot_o = q_q;
  assign done_o = busy_q && n_q == 6'd0;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i; r_q <= '0; d_q <= divisor_i;
    end else if (busy_q && n_q != 6'd0) begin
      if (!r_sub[lsap_pkg::DenW]) begin
        r_q <= r_sub; q_q <= {q_q[W-2:0], 1'b1};
      end else begin
        r_q <= r_sh; q_q <= {q_q[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; n_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1; n_q <= 6'(W);
    end else if (busy_q) begin
      if (n_q == 6'd0) busy_q <= 1'b0;
      else n_q <= n_q - 6'd1;
    end
  end
endmodule

FILE: src/lsap_back.sv
`timescale 1ns / 1ps
// scan engine: stores samples, calibrates, and walks the channels at scan end
module lsap_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                mode_i,
  input  logic signed [lsap_pkg::LvlW-1:0] thr_i,
  input  logic                avail_i,
  input  lsap_pkg::item_t     item_i,
  output logic                take_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output lsap_pkg::result_t   res_o
);
  localparam int DW = lsap_pkg::NumW + lsap_pkg::FracBits;
  logic [lsap_pkg::SmpW-1:0] lit_q [lsap_pkg::Channels];
  logic [lsap_pkg::SmpW-1:0] unl_q [lsap_pkg::Channels];
  logic signed [lsap_pkg::LvlW-1:0] dark_q [lsap_pkg::Channels];
  logic signed [lsap_pkg::LvlW-1:0] brt_q [lsap_pkg::Channels];

  lsap_pkg::bk_state_e st_q, st_d;
  logic [lsap_pkg::ChW-1:0] ch_q;
  logic signed [lsap_pkg::LvlW-1:0] lv_q, d_q, b_q;
  logic neg_q;
  logic signed [lsap_pkg::SvalW-1:0] sv_q;
  logic signed [lsap_pkg::NumW-1:0] num_q;
  logic signed [lsap_pkg::DenW-1:0] den_q;
  logic [15:0] bits_q;
  logic [4:0] cnt_q;
  logic dark_q1, uncal_q, ovalid_q;
  lsap_pkg::result_t res_q;

  logic div_start, div_done;
  logic [DW-1:0] div_a, div_q;
  logic [lsap_pkg::DenW-1:0] div_b;

  logic signed [lsap_pkg::LvlW-1:0] lv_c;
  logic signed [lsap_pkg::LvlW+2:0] bd_c, lv3_c;
  logic above_c;
  logic signed [lsap_pkg::LvlW:0] diff_c;
  logic [DW-1:0] qmag;
  logic signed [lsap_pkg::SvalW-1:0] sv_c;
  logic signed [4:0] wt_c;
  logic [DW-1:0] pmag;
  logic signed [lsap_pkg::PosW-1:0] pos_c;
  logic out_go;

  assign lv_c = lsap_pkg::LvlW'($signed({1'b0, lit_q[ch_q]}))
              - lsap_pkg::LvlW'($signed({1'b0, unl_q[ch_q]}));
  // level above (dark+bright)*2/3 truncated toward zero, checked as
  // 3*level > 2*(dark+bright), less 2 on the left when the sum is negative
  assign bd_c = (lsap_pkg::LvlW+3)'(b_q) + (lsap_pkg::LvlW+3)'(d_q);
  assign lv3_c = (lsap_pkg::LvlW+3)'(lv_q) + (lsap_pkg::LvlW+3)'(lv_q)
               + (lsap_pkg::LvlW+3)'(lv_q)
               - (bd_c[lsap_pkg::LvlW+2] ? (lsap_pkg::LvlW+3)'(2) : (lsap_pkg::LvlW+3)'(0));
  assign above_c = lv3_c > (bd_c <<< 1);
  assign diff_c = (lsap_pkg::LvlW+1)'(lv_q) - (lsap_pkg::LvlW+1)'(d_q);
  assign out_go = !ovalid_q || res_ready_i;

  always_comb begin
    qmag = div_q;
    if (qmag > DW'(lsap_pkg::SvalLim)) qmag = DW'(lsap_pkg::SvalLim);
    sv_c = neg_q ? -lsap_pkg::SvalW'(qmag) : lsap_pkg::SvalW'(qmag);
    pmag = div_q;
    if (pmag > DW'(lsap_pkg::PosLim)) pmag = DW'(lsap_pkg::PosLim);
    pos_c = neg_q ? -lsap_pkg::PosW'(pmag) : lsap_pkg::PosW'(pmag);
    if (ch_q < 4'd8) wt_c = 5'($signed({1'b0, ch_q})) - 5'sd8;
    else wt_c = 5'($signed({1'b0, ch_q})) - 5'sd7;
  end

  lsap_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_a),
    .divisor_i(div_b), .done_o(div_done), .quot_o(div_q)
  );

  always_comb begin
    st_d = st_q;
    take_o = 1'b0;
    div_start = 1'b0;
    div_a = '0;
    div_b = '0;
    case (st_q)
      lsap_pkg::BkIdle: begin
        if (avail_i) begin
          take_o = 1'b1;
          if (item_i.last) st_d = lsap_pkg::BkPrep;
        end
      end
      lsap_pkg::BkPrep: st_d = lsap_pkg::BkLoad;
      lsap_pkg::BkLoad: begin
        if (mode_i) st_d = lsap_pkg::BkIdle;
        else if (b_q > d_q) begin
          div_start = 1'b1;
          div_a = DW'(diff_c[lsap_pkg::LvlW] ? -diff_c : diff_c) << lsap_pkg::FracBits;
          div_b = lsap_pkg::DenW'(b_q - d_q);
          st_d = lsap_pkg::BkDiv;
        end else st_d = lsap_pkg::BkAcc;
      end
      lsap_pkg::BkDiv: if (div_done) st_d = lsap_pkg::BkAcc;
      lsap_pkg::BkAcc: begin
        if (ch_q == 4'd15) begin
          if (den_q == '0) st_d = lsap_pkg::BkOut;
          else begin
            div_start = 1'b1;
            div_a = DW'(num_q[lsap_pkg::NumW-1] ? -num_q : num_q) << lsap_pkg::FracBits;
            div_b = den_q[lsap_pkg::DenW-1] ? -den_q : den_q;
            st_d = lsap_pkg::BkPosDiv;
          end
        end else st_d = lsap_pkg::BkPrep;
      end
      lsap_pkg::BkPosDiv: if (div_done) st_d = lsap_pkg::BkOut;
      lsap_pkg::BkOut: if (out_go) st_d = lsap_pkg::BkIdle;
      default: st_d = lsap_pkg::BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= lsap_pkg::BkIdle;
      ovalid_q <= 1'b0;
      ch_q <= '0;
      for (int i = 0; i < lsap_pkg::Channels; i++) begin
        lit_q[i] <= '0; unl_q[i] <= '0;
        dark_q[i] <= lsap_pkg::LvlW'(lsap_pkg::DarkReset);
        brt_q[i] <= '0;
      end
    end else begin
      st_q <= st_d;
      if (st_q == lsap_pkg::BkOut && out_go) ovalid_q <= 1'b1;
      else if (ovalid_q && res_ready_i) ovalid_q <= 1'b0;
      if (take_o) begin
        if (item_i.led_on) lit_q[item_i.channel] <= item_i.sample;
        else unl_q[item_i.channel] <= item_i.sample;
        ch_q <= '0;
      end
      if (st_q == lsap_pkg::BkLoad && mode_i) begin
        for (int i = 0; i < lsap_pkg::Channels; i++) begin
          if ($signed({2'b0, lit_q[i]}) - $signed({2'b0, unl_q[i]}) < dark_q[i])
            dark_q[i] <= $signed({2'b0, lit_q[i]}) - $signed({2'b0, unl_q[i]});
          if ($signed({2'b0, lit_q[i]}) - $signed({2'b0, unl_q[i]}) > brt_q[i])
            brt_q[i] <= $signed({2'b0, lit_q[i]}) - $signed({2'b0, unl_q[i]});
        end
      end
      if (st_q == lsap_pkg::BkAcc && ch_q != 4'd15) ch_q <= ch_q + 4'd1;
    end
  end

  // per-channel datapath; operand registers are loaded during prep state, ahead of load state
  always_ff @(posedge clk_i) begin
    lv_q <= lv_c;
    d_q <= dark_q[ch_q];
    b_q <= brt_q[ch_q];
    if (take_o) begin
      num_q <= '0; den_q <= '0; bits_q <= '0; cnt_q <= '0;
      dark_q1 <= 1'b1; uncal_q <= 1'b0;
    end
    if (st_q == lsap_pkg::BkLoad) begin
      neg_q <= diff_c[lsap_pkg::LvlW];
      sv_q <= '0;
      if (!(b_q > d_q)) uncal_q <= 1'b1;
      bits_q <= {bits_q[14:0], above_c};
      if (above_c) cnt_q <= cnt_q + 5'd1;
    end
    if (st_q == lsap_pkg::BkDiv && div_done) sv_q <= sv_c;
    if (st_q == lsap_pkg::BkAcc) begin
      if (sv_q >= lsap_pkg::SvalW'(thr_i)) dark_q1 <= 1'b0;
      if (ch_q >= 4'd2 && ch_q <= 4'd13) begin
        den_q <= den_q + lsap_pkg::DenW'(sv_q);
        num_q <= num_q + lsap_pkg::NumW'(sv_q * wt_c);
      end
      if (ch_q == 4'd15) neg_q <= num_q[lsap_pkg::NumW-1] ^ den_q[lsap_pkg::DenW-1];
    end
    if (st_q == lsap_pkg::BkOut && out_go) begin
      res_q.position <= (den_q == '0) ? '0 : pos_c;
      res_q.line_bits <= bits_q;
      res_q.lit_count <= cnt_q;
      res_q.all_dark <= dark_q1;
      res_q.no_line <= den_q == '0;
      res_q.uncalibrated <= uncal_q;
    end
  end

  assign res_valid_o = ovalid_q;
  assign res_o = res_q;

`ifndef NO_ASSERTIONS
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |-> st_q == lsap_pkg::BkIdle) else $error("take while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !res_ready_i |=> ovalid_q && $stable(res_q)) else $error("result lost");
  a_ch_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == lsap_pkg::BkAcc && ch_q != 4'd15 |=> ch_q == $past(ch_q) + 4'd1)
    else $error("channel walk skipped");
`endif
endmodule

FILE: src/line_sensor_array_processor.sv
`timescale 1ns / 1ps
// 16-channel reflective line sensor processor.
// input channel: samples (channel, led_on, sample, last) are pushed with
// push while full is low; a two-entry queue absorbs them. each sample is
// stored as the lit or unlit reading of its channel; the idle engine
// takes whatever sample waits, so plain samples can stream back to back.
// a transaction with last set ends a scan. in calibration mode the per
// channel dark/bright levels are updated and no result comes. in run mode
// the engine walks the 16 channels: prep, load, a division on the shared
// serial divider for a calibrated channel only, and accumulate; then the
// centroid division on the same divider (when the level sum is nonzero)
// and the output state, which waits while an earlier result is unpopped.
// no samples are taken during the walk.
// result channel: the result is shown while empty is low and taken with
// pop; a stalled result holds the output register, the engine keeps taking
// samples until the next scan end, and then the queue fills and full rises.
// reset clears stored samples, calibration (dark 1024, bright 0), mode 0
// and dark threshold 128. config writes only while idle.
module line_sensor_array_processor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [3:0]  channel_i,
  input  logic        led_on_i,
  input  logic [9:0]  sample_i,
  input  logic        last_i,
  output logic        empty,
  input  logic        pop,
  output logic signed [11:0] position_o,
  output logic [15:0] line_bits_o,
  output logic [4:0]  lit_count_o,
  output logic        all_dark_o,
  output logic        no_line_o,
  output logic        uncalibrated_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [11:0] cfg_data_i
);
  logic mode_q;
  logic signed [11:0] thr_q;
  lsap_pkg::item_t in_item, q_item;
  lsap_pkg::result_t res;
  logic avail, take, rvalid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      thr_q <= 12'(lsap_pkg::ThrReset);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lsap_pkg::RegMode: mode_q <= cfg_data_i[0];
        lsap_pkg::RegThr: thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_item = '{last: last_i, channel: channel_i, led_on: led_on_i, sample: sample_i};

  lsap_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .item_i(in_item),
    .avail_o(avail), .take_i(take), .item_o(q_item)
  );

  lsap_back u_back (
    .clk_i, .rst_ni, .mode_i(mode_q), .thr_i(thr_q), .avail_i(avail),
    .item_i(q_item), .take_o(take), .res_valid_o(rvalid), .res_ready_i(pop),
    .res_o(res)
  );

  assign empty = !rvalid;
  assign position_o = res.position;
  assign line_bits_o = res.line_bits;
  assign lit_count_o = res.lit_count;
  assign all_dark_o = res.all_dark;
  assign no_line_o = res.no_line;
  assign uncalibrated_o = res.uncalibrated;
endmodule

FILE: tb/sv/lsap_checker.sv
`timescale 1ns / 1ps
module lsap_checker
  import lsap_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  input  logic                      full,
  input  logic [3:0]                channel_i,
  input  logic                      led_on_i,
  input  logic [9:0]                sample_i,
  input  logic                      last_i,
  input  logic                      empty,
  input  logic                      pop,
  input  logic signed [PosW-1:0]    position_o,
  input  logic [15:0]               line_bits_o,
  input  logic [4:0]                lit_count_o,
  input  logic                      all_dark_o,
  input  logic                      no_line_o,
  input  logic                      uncalibrated_o,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_idx_i,
  input  logic [11:0]               cfg_data_i,
  output int                        fails,
  output int                        pending
);

  logic [SmpW-1:0] lit_smp [Channels];
  logic [SmpW-1:0] unlit_smp [Channels];
  int              dark_lvl [Channels];
  int              bright_lvl [Channels];
  logic            calib_mode;
  int              dark_thr;
  result_t         scan_results [$];

  assign pending = scan_results.size();

  function automatic result_t eval_scan();
    result_t r;
    longint  sv [Channels];
    longint  q, num, den, pos;
    int      lv, thr3, w, cnt;
    logic    dark_all, uncal;
    logic [15:0] bits;
    dark_all = 1'b1;
    uncal = 1'b0;
    bits = '0;
    cnt = 0;
    for (int i = 0; i < Channels; i++) begin
      lv = int'(lit_smp[i]) - int'(unlit_smp[i]);
      thr3 = ((bright_lvl[i] + dark_lvl[i]) * 2) / 3;
      q = 0;
      if (bright_lvl[i] > dark_lvl[i]) begin
        q = (longint'(lv - dark_lvl[i]) * (longint'(1) <<< FracBits)) /
            longint'(bright_lvl[i] - dark_lvl[i]);
        if (q > SvalLim) q = SvalLim;
        if (q < -SvalLim) q = -SvalLim;
      end else begin
        uncal = 1'b1;
      end
      sv[i] = q;
      if (q >= dark_thr) dark_all = 1'b0;
      bits = {bits[14:0], lv > thr3};
      if (lv > thr3) cnt++;
    end
    // weights -6..-1, 1..6 over channels 2..13
    num = 0;
    den = 0;
    w = -6;
    for (int i = 2; i < 14; i++) begin
      den += sv[i];
      num += sv[i] * w;
      w++;
      if (w == 0) w = 1;
    end
    pos = 0;
    if (den != 0) begin
      pos = (num * (longint'(1) <<< FracBits)) / den;
      if (pos > PosLim) pos = PosLim;
      if (pos < -PosLim) pos = -PosLim;
    end
    r.position = pos[PosW-1:0];
    r.line_bits = bits;
    r.lit_count = cnt[4:0];
    r.all_dark = dark_all;
    r.no_line = (den == 0);
    r.uncalibrated = uncal;
    return r;
  endfunction

  task automatic report(string field, longint exp_v, longint act_v);
    fails++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t e;
    int lv;
    if (!rst_ni) begin
      for (int i = 0; i < Channels; i++) begin
        lit_smp[i] <= '0;
        unlit_smp[i] <= '0;
        dark_lvl[i] <= DarkReset;
        bright_lvl[i] <= 0;
      end
      calib_mode <= 1'b0;
      dark_thr <= ThrReset;
      fails <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegMode) calib_mode = cfg_data_i[0];
        else if (cfg_idx_i == RegThr) dark_thr = int'($signed(cfg_data_i));
      end
      if (push && !full) begin
        if (led_on_i) lit_smp[channel_i] = sample_i;
        else unlit_smp[channel_i] = sample_i;
        if (last_i) begin
          if (calib_mode) begin
            for (int i = 0; i < Channels; i++) begin
              lv = int'(lit_smp[i]) - int'(unlit_smp[i]);
              if (lv < dark_lvl[i]) dark_lvl[i] = lv;
              if (lv > bright_lvl[i]) bright_lvl[i] = lv;
            end
          end else begin
            scan_results.push_back(eval_scan());
          end
        end
      end
      if (pop && !empty) begin
        if (scan_results.size() == 0) begin
          fails++;
          $display("%0t: result with none expected, actual position %0d bits %h",
                   $time, position_o, line_bits_o);
        end else begin
          e = scan_results.pop_front();
          if (e.position !== position_o) report("position", e.position, position_o);
          if (e.line_bits !== line_bits_o) report("line_bits", e.line_bits, line_bits_o);
          if (e.lit_count !== lit_count_o) report("lit_count", e.lit_count, lit_count_o);
          if (e.all_dark !== all_dark_o) report("all_dark", e.all_dark, all_dark_o);
          if (e.no_line !== no_line_o) report("no_line", e.no_line, no_line_o);
          if (e.uncalibrated !== uncalibrated_o)
            report("uncalibrated", e.uncalibrated, uncalibrated_o);
        end
      end
    end
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import lsap_pkg::*;

  localparam int CycleLimit = 8000000;
  localparam int DrainCycles = 800;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [3:0]         channel_i = '0;
  logic               led_on_i = 1'b0;
  logic [9:0]         sample_i = '0;
  logic               last_i = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [11:0] position_o;
  logic [15:0]        line_bits_o;
  logic [4:0]         lit_count_o;
  logic               all_dark_o, no_line_o, uncalibrated_o;
  logic               cfg_we_i = 1'b0;
  logic [0:0]         cfg_idx_i = RegMode;
  logic [11:0]        cfg_data_i = '0;
  int                 fails, pending, cycles, sent, popped;
  logic               eager_send = 1'b0;
  logic               eager_pop = 1'b0;

  line_sensor_array_processor dut (.*);

  lsap_checker chk (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send(int ch, logic led, int smp, logic lst);
    int gap;
    gap = eager_send ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    channel_i <= ch[3:0];
    led_on_i <= led;
    sample_i <= smp[9:0];
    last_i <= lst;
    do @(posedge clk_i); while (full);
    sent++;
  endtask

  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [11:0] data);
    settle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // one scan: unlit then lit per channel, levels from a line profile
  // kind 0 dark, 1 bright, 2 line at center, 3 fully random samples
  task automatic scan(int kind, int center, int half_w);
    int lvl, base, lit, start, ch;
    start = $urandom_range(0, 15);
    for (int k = 0; k < Channels; k++) begin
      ch = (start + k) % Channels;
      base = $urandom_range(0, 200);
      case (kind)
        0: lvl = $urandom_range(0, 40);
        1: lvl = $urandom_range(700, 820);
        2: begin
          if (ch >= center - half_w && ch <= center + half_w)
            lvl = $urandom_range(600, 823);
          else
            lvl = $urandom_range(0, 120);
        end
        default: lvl = 0;
      endcase
      lit = base + lvl;
      if (kind == 3) begin
        base = $urandom_range(0, 1023);
        lit = $urandom_range(0, 1023);
      end
      send(ch, 1'b0, base, 1'b0);
      send(ch, 1'b1, lit, k == Channels - 1);
    end
  endtask

  // receiver: random stalls, runs without stall, one long hold
  initial begin
    int stall;
    popped = 0;
    @(posedge rst_ni);
    forever begin
      stall = eager_pop ? 0 : $urandom_range(0, 18);
      if (popped == 20) stall = 4000;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      popped++;
    end
  end

  initial begin
    int r;
    cycles = 0;
    sent = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // uncalibrated state right after reset, field extremes
    send(0, 1'b1, 1023, 1'b0);
    send(15, 1'b0, 0, 1'b0);
    send(7, 1'b1, 0, 1'b1);
    send(15, 1'b1, 1023, 1'b1);
    send(0, 1'b0, 1023, 1'b1);

    // calibrate: dark, bright, and one negative-level channel
    write_reg(RegMode, 12'd1);
    scan(0, 0, 0);
    scan(1, 0, 0);
    send(5, 1'b0, 1023, 1'b0);
    send(5, 1'b1, 0, 1'b1);
    send(5, 1'b1, 300, 1'b1);
    write_reg(RegMode, 12'd0);

    scan(2, 2, 0);
    scan(2, 13, 0);
    scan(0, 0, 0);
    scan(1, 0, 0);
    write_reg(RegThr, 12'h400);
    scan(0, 0, 0);
    write_reg(RegThr, 12'hC00);
    scan(2, 7, 2);
    write_reg(RegThr, 12'h7FF);
    scan(3, 0, 0);
    write_reg(RegThr, 12'd128);

    while (sent < 1900) begin
      r = $urandom_range(0, 99);
      eager_send = ($urandom_range(0, 5) == 0);
      eager_pop = ($urandom_range(0, 5) == 0);
      if (r < 4) begin
        write_reg(RegMode, 12'd1);
        repeat ($urandom_range(1, 3)) scan($urandom_range(0, 3), 0, 0);
        write_reg(RegMode, 12'd0);
      end else if (r < 8) begin
        write_reg(RegThr, 12'($urandom_range(0, 4095)));
      end else if (r < 16) begin
        repeat ($urandom_range(1, 6))
          send($urandom_range(0, 15), 1'($urandom), $urandom_range(0, 1023),
               $urandom_range(0, 3) == 0);
      end else if (r < 24) begin
        scan(3, 0, 0);
      end else if (r < 28) begin
        scan($urandom_range(0, 1), 0, 0);
      end else begin
        scan(2, $urandom_range(0, 15), $urandom_range(0, 3));
      end
    end

    eager_send = 1'b0;
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fails == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
